FILE: hdl/bsp_pkg.sv
// Package: shared types, constants and fixed-point helpers for the pixel iterator.
package bsp_pkg;

  localparam int IMAGE_SIZE  = 1024;
  localparam int FRAC_BITS   = 28;
  localparam int WORD_BITS   = FRAC_BITS + 4;
  localparam int WIDE_BITS   = WORD_BITS + 16;
  localparam int COORD_BITS  = 10;
  localparam int LIMIT_BITS  = 16;
  localparam int STEP_BITS   = 31;
  localparam int COLOUR_BITS = 24;
  localparam int PIXEL_BITS  = 32;
  localparam int CMOD_BITS   = 8;
  localparam int COLOUR_MOD  = 255;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  typedef logic [COORD_BITS-1:0]         coord_t;
  typedef logic [LIMIT_BITS-1:0]         count_t;
  typedef logic [STEP_BITS-1:0]          step_t;
  typedef logic [COLOUR_BITS-1:0]        colour_t;
  typedef logic [PIXEL_BITS-1:0]         pixel_t;
  typedef logic [CMOD_BITS-1:0]          cmod_t;
  typedef logic signed [WORD_BITS-1:0]   word_t;
  typedef logic signed [WIDE_BITS-1:0]   wide_t;
  typedef logic [CFG_IDX_BITS-1:0]       cfg_idx_t;
  typedef logic [CFG_DATA_BITS-1:0]      cfg_data_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ITER_LIMIT  = 3'd0,
    CFG_PIXEL_STEP  = 3'd1,
    CFG_ORIGIN_RE   = 3'd2,
    CFG_ORIGIN_IM   = 3'd3,
    CFG_BASE_COLOUR = 3'd4,
    CFG_ESC_LIMIT   = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ITER_A,
    S_ITER_B,
    S_DONE
  } back_state_t;

  typedef struct packed {
    coord_t px;
    coord_t py;
    word_t  cr;
    word_t  ci;
    logic   outside;
  } item_t;

  typedef struct packed {
    logic pop;
    logic step_a;
    logic step_b;
    logic set_esc;
    logic load_out;
  } back_ctl_t;

  function automatic wide_t sx(word_t v);
    sx = {{(WIDE_BITS-WORD_BITS){v[WORD_BITS-1]}}, v};
  endfunction

  function automatic word_t sat(wide_t v);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[WIDE_BITS-1:WORD_BITS-1];
    hi_zeros = ~|v[WIDE_BITS-1:WORD_BITS-1];
    if (hi_ones || hi_zeros) begin
      sat = v[WORD_BITS-1:0];
    end else if (v[WIDE_BITS-1]) begin
      sat = {1'b1, {(WORD_BITS-1){1'b0}}};
    end else begin
      sat = {1'b0, {(WORD_BITS-1){1'b1}}};
    end
  endfunction

  function automatic word_t abs_sat(word_t v);
    if (v[WORD_BITS-1]) begin
      abs_sat = sat(-sx(v));
    end else begin
      abs_sat = v;
    end
  endfunction

  // Magnitude product truncated toward zero, signed and saturated.
  function automatic word_t fmul(word_t a, word_t b);
    logic [WORD_BITS-1:0]   ua;
    logic [WORD_BITS-1:0]   ub;
    logic [2*WORD_BITS-1:0] p;
    logic [2*WORD_BITS-1:0] r;
    logic [2*WORD_BITS-1:0] cap;
    logic                   neg;
    ua  = a[WORD_BITS-1] ? WORD_BITS'(-a) : WORD_BITS'(a);
    ub  = b[WORD_BITS-1] ? WORD_BITS'(-b) : WORD_BITS'(b);
    p   = {{WORD_BITS{1'b0}}, ua} * {{WORD_BITS{1'b0}}, ub};
    r   = p >> FRAC_BITS;
    neg = a[WORD_BITS-1] ^ b[WORD_BITS-1];
    cap = neg ? {{(WORD_BITS+1){1'b0}}, 1'b1, {(WORD_BITS-2){1'b0}}} << 1
              : {{(WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
    if (r > cap) begin
      r = cap;
    end
    fmul = neg ? -word_t'(r[WORD_BITS-1:0]) : word_t'(r[WORD_BITS-1:0]);
  endfunction

endpackage

FILE: hdl/bsp_if.sv
// Interfaces: pixel request channel and pixel result channel.
interface bsp_in_if;
  logic             valid;
  logic             ready;
  bsp_pkg::coord_t  pixel_x;
  bsp_pkg::coord_t  pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface bsp_out_if;
  logic             valid;
  logic             ready;
  bsp_pkg::coord_t  out_x;
  bsp_pkg::coord_t  out_y;
  bsp_pkg::pixel_t  pixel_colour;
  logic             escaped;
  bsp_pkg::count_t  iterations_done;

  modport source (output valid, output out_x, output out_y, output pixel_colour,
                  output escaped, output iterations_done, input ready);
  modport sink   (input valid, input out_x, input out_y, input pixel_colour,
                  input escaped, input iterations_done, output ready);
endinterface

FILE: hdl/burning_ship_pixel_iterator.sv
// Top level: Burning Ship escape-time pixel iterator with configuration registers.
//
// Send a pixel coordinate as one beat on in_pix; one result beat comes back on
// out_res with the coordinate echoed, the escape flag, the iteration count and
// the colour. Results leave in the order the pixels came in.
// Write registers through cfg_we/cfg_index/cfg_data only while no pixel is in
// flight; unknown indexes are dropped.
// The iteration engine runs the map for one pixel at a time; a pixel outside the
// frame skips the map and goes straight to its result.
// Up to three pixels wait ahead of the engine (one front stage, two queue
// entries), so in_pix keeps taking beats while a pixel iterates.
// A finished result holds in the output register while out_res.ready is low;
// the engine then stalls, the queue fills, and in_pix.ready drops.
// Reset (rst_n low, synchronous) empties the pipeline and restores the
// register defaults.
module burning_ship_pixel_iterator (
  input  logic                clk,
  input  logic                rst_n,
  bsp_in_if.sink              in_pix,
  bsp_out_if.source           out_res,
  input  logic                cfg_we,
  input  bsp_pkg::cfg_idx_t   cfg_index,
  input  bsp_pkg::cfg_data_t  cfg_data
);
  import bsp_pkg::*;

  count_t  iter_limit_r;
  step_t   pixel_step_r;
  word_t   origin_re_r;
  word_t   origin_im_r;
  colour_t base_colour_r;
  step_t   esc_limit_r;

  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_nonempty;
  item_t q_in;
  item_t q_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_limit_r  <= count_t'(100);
      pixel_step_r  <= step_t'(1342177);
      origin_re_r   <= word_t'(-536870912);
      origin_im_r   <= word_t'(-536870912);
      base_colour_r <= colour_t'(263172);
      esc_limit_r   <= step_t'(1073741824);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ITER_LIMIT:  iter_limit_r  <= cfg_data[LIMIT_BITS-1:0];
        CFG_PIXEL_STEP:  pixel_step_r  <= cfg_data[STEP_BITS-1:0];
        CFG_ORIGIN_RE:   origin_re_r   <= cfg_data[WORD_BITS-1:0];
        CFG_ORIGIN_IM:   origin_im_r   <= cfg_data[WORD_BITS-1:0];
        CFG_BASE_COLOUR: base_colour_r <= cfg_data[COLOUR_BITS-1:0];
        CFG_ESC_LIMIT:   esc_limit_r   <= cfg_data[STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  bsp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_pix      (in_pix),
    .pixel_step  (pixel_step_r),
    .origin_real (origin_re_r),
    .origin_imag (origin_im_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (q_in)
  );

  bsp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .pop_item  (q_out)
  );

  bsp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_nonempty      (q_nonempty),
    .q_item          (q_out),
    .q_pop           (q_pop),
    .iteration_limit (iter_limit_r),
    .base_colour     (base_colour_r),
    .escape_limit    (esc_limit_r),
    .out_res         (out_res)
  );

endmodule

FILE: hdl/bsp_front.sv
// Front end: accept pixel beats, map coordinates to the plane, flag out-of-frame pixels.
module bsp_front (
  input  logic            clk,
  input  logic            rst_n,
  bsp_in_if.sink          in_pix,
  input  bsp_pkg::step_t  pixel_step,
  input  bsp_pkg::word_t  origin_real,
  input  bsp_pkg::word_t  origin_imag,
  input  logic            q_full,
  output logic            q_push,
  output bsp_pkg::item_t  q_item
);
  import bsp_pkg::*;

  localparam int PROD_BITS = COORD_BITS + STEP_BITS;

  logic   stg_v_r;
  coord_t stg_x_r;
  coord_t stg_y_r;
  logic [PROD_BITS-1:0] prod_x;
  logic [PROD_BITS-1:0] prod_y;

  assign in_pix.ready = !stg_v_r || !q_full;
  assign q_push       = stg_v_r && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (in_pix.ready) begin
      stg_v_r <= in_pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_pix.ready && in_pix.valid) begin
      stg_x_r <= in_pix.pixel_x;
      stg_y_r <= in_pix.pixel_y;
    end
  end

  assign prod_x = {{STEP_BITS{1'b0}}, stg_x_r} * {{COORD_BITS{1'b0}}, pixel_step};
  assign prod_y = {{STEP_BITS{1'b0}}, stg_y_r} * {{COORD_BITS{1'b0}}, pixel_step};

  always_comb begin
    q_item.px      = stg_x_r;
    q_item.py      = stg_y_r;
    q_item.cr      = sat(wide_t'({{(WIDE_BITS-PROD_BITS){1'b0}}, prod_x}) + sx(origin_real));
    q_item.ci      = sat(wide_t'({{(WIDE_BITS-PROD_BITS){1'b0}}, prod_y}) + sx(origin_imag));
    q_item.outside = (int'(stg_x_r) >= IMAGE_SIZE) || (int'(stg_y_r) >= IMAGE_SIZE);
  end

endmodule

FILE: hdl/bsp_queue.sv
// Two-entry queue between the front end and the iteration engine.
module bsp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bsp_pkg::item_t  push_item,
  output logic            full,
  input  logic            pop,
  output logic            nonempty,
  output bsp_pkg::item_t  pop_item
);
  import bsp_pkg::*;

  item_t      mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign full     = cnt_r[1];
  assign nonempty = cnt_r != 2'd0;
  assign pop_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: hdl/bsp_back.sv
// Iteration engine: run the map one iteration at a time through S_ITER_A and S_ITER_B, and hold the result beat.
module bsp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_nonempty,
  input  bsp_pkg::item_t     q_item,
  output logic               q_pop,
  input  bsp_pkg::count_t    iteration_limit,
  input  bsp_pkg::colour_t   base_colour,
  input  bsp_pkg::step_t     escape_limit,
  bsp_out_if.source          out_res
);
  import bsp_pkg::*;

  back_state_t state_r;
  back_state_t state_nxt;
  back_ctl_t   ctl;

  coord_t px_r;
  coord_t py_r;
  word_t  cr_r;
  word_t  ci_r;
  word_t  x_r;
  word_t  y_r;
  word_t  x2_r;
  word_t  y2_r;
  word_t  xy_r;
  count_t count_r;
  cmod_t  cmod_r;
  logic   esc_r;
  logic   out_v_r;

  logic   out_free;
  logic   hit_esc;
  logic   hit_lim;
  word_t  xn;
  word_t  yn;

  assign out_free = !out_v_r || out_res.ready;
  assign hit_esc  = (count_r != '0) &&
                    (sx(x2_r) + sx(y2_r) >= wide_t'({{(WIDE_BITS-STEP_BITS){1'b0}}, escape_limit}));
  assign hit_lim  = count_r == iteration_limit;
  assign xn       = abs_sat(sat(sx(x2_r) - sx(y2_r) + sx(cr_r)));
  assign yn       = sat(sx(abs_sat(sat(sx(xy_r) + sx(xy_r)))) + sx(ci_r));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (q_nonempty) begin
          state_nxt = q_item.outside ? S_DONE : S_ITER_A;
        end
      end
      S_ITER_A: begin
        state_nxt = (hit_esc || hit_lim) ? S_DONE : S_ITER_B;
      end
      S_ITER_B: begin
        state_nxt = S_ITER_A;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state_r)
      S_IDLE:   ctl.pop      = q_nonempty;
      S_ITER_A: begin
        ctl.set_esc = hit_esc;
        ctl.step_a  = !hit_esc && !hit_lim;
      end
      S_ITER_B: ctl.step_b   = 1'b1;
      S_DONE:   ctl.load_out = out_free;
      default:  ctl = '0;
    endcase
  end

  assign q_pop = ctl.pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ctl.load_out) begin
        out_v_r <= 1'b1;
      end else if (out_res.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      px_r    <= q_item.px;
      py_r    <= q_item.py;
      cr_r    <= q_item.cr;
      ci_r    <= q_item.ci;
      x_r     <= '0;
      y_r     <= '0;
      x2_r    <= '0;
      y2_r    <= '0;
      count_r <= '0;
      cmod_r  <= '0;
      esc_r   <= 1'b0;
    end
    if (ctl.step_a) begin
      xy_r    <= fmul(x_r, y_r);
      x_r     <= xn;
      x2_r    <= fmul(xn, xn);
      count_r <= count_r + count_t'(1);
      cmod_r  <= (int'(cmod_r) == COLOUR_MOD - 1) ? '0 : cmod_r + cmod_t'(1);
    end
    if (ctl.step_b) begin
      y_r  <= yn;
      y2_r <= fmul(yn, yn);
    end
    if (ctl.set_esc) begin
      esc_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_res.out_x           <= px_r;
      out_res.out_y           <= py_r;
      out_res.escaped         <= esc_r;
      out_res.iterations_done <= count_r;
      out_res.pixel_colour    <= esc_r ? {{CMOD_BITS{1'b0}}, base_colour} *
                                         {{COLOUR_BITS{1'b0}}, cmod_r} : '0;
    end
  end

  assign out_res.valid = out_v_r;

endmodule

FILE: dv/testbench.sv
// Testbench for the Burning Ship pixel iterator: directed and random pixels checked against a predictor.
module testbench;
  import bsp_pkg::*;

  localparam longint WORD_HI = (longint'(1) <<< (WORD_BITS - 1)) - 1;
  localparam longint WORD_LO = -WORD_HI - 1;
  localparam int MAX_WAIT = 13;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_PIXELS = 230;
  localparam int REPORT_CAP = 100;
  localparam coord_t COORD_MAX = coord_t'(IMAGE_SIZE - 1);

  localparam cfg_idx_t CFG_SPARE_LO = 3'd6;
  localparam cfg_idx_t CFG_SPARE_HI = 3'd7;

  localparam count_t    LIMIT_RESET  = 16'd100;
  localparam step_t     STEP_RESET   = 31'd1342177;
  localparam int        ORIGIN_RESET = -536870912;
  localparam colour_t   COLOUR_RESET = 24'd263172;
  localparam step_t     ESCAPE_FOUR  = 31'd1073741824;
  localparam cfg_data_t WORD_MAX_BITS = 32'h7FFF_FFFF;
  localparam cfg_data_t WORD_MIN_BITS = 32'h8000_0000;
  localparam cfg_data_t QUARTER_PLUS  = 32'd67130339;

  typedef struct {
    coord_t x;
    coord_t y;
    pixel_t colour;
    logic   escaped;
    count_t iterations;
  } pixel_result_t;

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_data;

  bsp_in_if  pix_in ();
  bsp_out_if pix_out ();

  burning_ship_pixel_iterator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (pix_in),
    .out_res   (pix_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  count_t  iter_limit_q = LIMIT_RESET;
  step_t   step_q       = STEP_RESET;
  int      origin_re_q  = ORIGIN_RESET;
  int      origin_im_q  = ORIGIN_RESET;
  colour_t colour_q     = COLOUR_RESET;
  step_t   escape_q     = ESCAPE_FOUR;

  pixel_result_t pending_pixels[$];
  int error_count = 0;
  int cycle_count = 0;
  bit throttle = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp_word(longint v);
    if (v > WORD_HI) return WORD_HI;
    if (v < WORD_LO) return WORD_LO;
    return v;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint unsigned ma;
    longint unsigned mb;
    longint unsigned q;
    longint unsigned cap;
    bit neg;
    ma = (a < 0) ? longint'(-a) : a;
    mb = (b < 0) ? longint'(-b) : b;
    q = (ma * mb) >> FRAC_BITS;
    neg = (a < 0) != (b < 0);
    cap = neg ? longint'(WORD_HI) + 1 : longint'(WORD_HI);
    if (q > cap) q = cap;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint fx_abs(longint v);
    return (v < 0) ? clamp_word(-v) : v;
  endfunction

  function automatic pixel_result_t escape_time_pixel(coord_t px, coord_t py);
    pixel_result_t r;
    longint cr;
    longint ci;
    longint x;
    longint y;
    longint re;
    longint im;
    int unsigned n;
    bit gone;
    n = 0;
    gone = 1'b0;
    if (px < IMAGE_SIZE && py < IMAGE_SIZE) begin
      cr = clamp_word(longint'(px) * longint'(step_q) + longint'(origin_re_q));
      ci = clamp_word(longint'(py) * longint'(step_q) + longint'(origin_im_q));
      x = 0;
      y = 0;
      while (n < iter_limit_q && !gone) begin
        n++;
        re = clamp_word(fx_mul(x, x) - fx_mul(y, y) + cr);
        im = clamp_word(fx_abs(clamp_word(2 * fx_mul(x, y))) + ci);
        x = fx_abs(re);
        y = im;
        gone = (fx_mul(x, x) + fx_mul(y, y)) >= longint'(escape_q);
      end
    end
    r.x = px;
    r.y = py;
    r.escaped = gone;
    r.iterations = count_t'(n);
    r.colour = gone ? pixel_t'(longint'(colour_q) * (n % COLOUR_MOD)) : '0;
    return r;
  endfunction

  task automatic report_mismatch(string field, coord_t x, coord_t y, longint got,
                                 longint want);
    if (error_count < REPORT_CAP) begin
      $display("MISMATCH %s pixel (%0d,%0d): got %0h want %0h, cycle %0d",
               field, x, y, got, want, cycle_count);
    end
    error_count++;
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_ITER_LIMIT:  iter_limit_q = data[LIMIT_BITS-1:0];
      CFG_PIXEL_STEP:  step_q = data[STEP_BITS-1:0];
      CFG_ORIGIN_RE:   origin_re_q = data;
      CFG_ORIGIN_IM:   origin_im_q = data;
      CFG_BASE_COLOUR: colour_q = data[COLOUR_BITS-1:0];
      CFG_ESC_LIMIT:   escape_q = data[STEP_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_view(cfg_data_t limit, cfg_data_t step, cfg_data_t ore,
                           cfg_data_t oim, cfg_data_t colour, cfg_data_t escape);
    write_reg(CFG_ITER_LIMIT, limit);
    write_reg(CFG_PIXEL_STEP, step);
    write_reg(CFG_ORIGIN_RE, ore);
    write_reg(CFG_ORIGIN_IM, oim);
    write_reg(CFG_BASE_COLOUR, colour);
    write_reg(CFG_ESC_LIMIT, escape);
  endtask

  task automatic send_pixel(coord_t x, coord_t y);
    int gap;
    gap = throttle ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap != 0) begin
      pix_in.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_in.valid <= 1'b1;
    pix_in.pixel_x <= x;
    pix_in.pixel_y <= y;
    do @(posedge clk); while (!pix_in.ready);
    pending_pixels.push_back(escape_time_pixel(x, y));
    @(negedge clk);
  endtask

  task automatic settle_pipeline();
    pix_in.valid <= 1'b0;
    @(negedge clk);
    while (pending_pixels.size() != 0) @(negedge clk);
  endtask

  task automatic test_power_on_defaults();
    send_pixel('0, '0);
    send_pixel(COORD_MAX, COORD_MAX);
    send_pixel('0, COORD_MAX);
    send_pixel(COORD_MAX, '0);
    send_pixel(10'b0101010101, 10'b1010101010);
    send_pixel(10'b1000000000, 10'b0111111111);
    settle_pipeline();
  endtask

  task automatic test_register_extremes();
    // zero iteration limit: no map step at all
    load_view('0, cfg_data_t'(STEP_RESET), ORIGIN_RESET, ORIGIN_RESET,
              cfg_data_t'(COLOUR_RESET), cfg_data_t'(ESCAPE_FOUR));
    send_pixel('0, '0);
    send_pixel(COORD_MAX, COORD_MAX);
    settle_pipeline();
    // zero escape limit: every orbit escapes on its first step
    load_view(1, cfg_data_t'(STEP_RESET), ORIGIN_RESET, ORIGIN_RESET,
              cfg_data_t'(COLOUR_RESET), '0);
    send_pixel(10'd700, 10'd300);
    settle_pipeline();
    // widest step and most negative origins: c runs from the most negative word up to positive saturation
    load_view(20, WORD_MAX_BITS, WORD_MIN_BITS, WORD_MIN_BITS, 32'hFF_FFFF, WORD_MAX_BITS);
    send_pixel('0, '0);
    send_pixel(COORD_MAX, COORD_MAX);
    send_pixel(10'd1, '0);
    send_pixel(COORD_MAX, '0);
    settle_pipeline();
    // most positive origins with a black base colour
    load_view(20, 1, WORD_MAX_BITS, WORD_MAX_BITS, '0, 1);
    send_pixel(COORD_MAX, COORD_MAX);
    settle_pipeline();
    // c = 0 never escapes: run the full 16-bit limit once
    load_view(32'hFFFF, '0, '0, '0, 1, 1);
    send_pixel(10'd512, 10'd512);
    settle_pipeline();
    // writes past the register list must leave every register alone
    load_view(30, cfg_data_t'(STEP_RESET), ORIGIN_RESET, ORIGIN_RESET,
              cfg_data_t'(COLOUR_RESET), cfg_data_t'(ESCAPE_FOUR));
    write_reg(CFG_SPARE_LO, $urandom());
    write_reg(CFG_SPARE_HI, $urandom());
    send_pixel(10'd300, 10'd500);
    settle_pipeline();
  endtask

  task automatic test_colour_wraparound();
    pixel_result_t r;
    int hit;
    hit = -1;
    // real axis just past c = 1/4: escape count falls slowly across the row
    load_view(600, 64, QUARTER_PLUS, '0, 32'hFF_FFFF, cfg_data_t'(ESCAPE_FOUR));
    for (int px = 0; px < IMAGE_SIZE; px++) begin
      r = escape_time_pixel(coord_t'(px), '0);
      if (r.escaped && (r.iterations % COLOUR_MOD) == 0) begin
        hit = px;
        break;
      end
    end
    if (hit < 0) hit = 1;
    send_pixel(coord_t'(hit), '0);
    send_pixel(coord_t'(hit - 1), '0);
    if (hit < IMAGE_SIZE - 1) send_pixel(coord_t'(hit + 1), '0);
    settle_pipeline();
  endtask

  task automatic test_random_frames();
    cfg_data_t step;
    cfg_data_t ore;
    cfg_data_t oim;
    cfg_data_t escape;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) begin
        load_view(cfg_data_t'(LIMIT_RESET), cfg_data_t'(STEP_RESET), ORIGIN_RESET,
                  ORIGIN_RESET, cfg_data_t'(COLOUR_RESET), cfg_data_t'(ESCAPE_FOUR));
      end else begin
        step = ($urandom_range(0, 7) == 0) ? $urandom_range(0, WORD_MAX_BITS)
                                           : $urandom_range(200000, 2700000);
        ore = ($urandom_range(0, 7) == 0) ? $urandom()
                                          : int'($urandom_range(0, 805306368)) - 671088640;
        oim = ($urandom_range(0, 7) == 0) ? $urandom()
                                          : int'($urandom_range(0, 805306368)) - 671088640;
        escape = ($urandom_range(0, 3) == 0) ? $urandom_range(1, WORD_MAX_BITS)
                                             : cfg_data_t'(ESCAPE_FOUR);
        load_view($urandom_range(1, 150), step, ore, oim, $urandom_range(0, 24'hFF_FFFF),
                  escape);
        if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE_HI, $urandom());
      end
      throttle = (phase % 4) != 3;
      for (int i = 0; i < PHASE_PIXELS; i++) begin
        send_pixel(coord_t'($urandom_range(0, IMAGE_SIZE - 1)),
                   coord_t'($urandom_range(0, IMAGE_SIZE - 1)));
      end
      settle_pipeline();
    end
    throttle = 1'b1;
  endtask

  initial begin : result_sink
    int stall;
    pix_out.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = throttle ? $urandom_range(0, MAX_WAIT) : 0;
      if (stall != 0) begin
        pix_out.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      pix_out.ready <= 1'b1;
      do @(posedge clk); while (!pix_out.valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    pixel_result_t want;
    if (rst_n && pix_out.valid && pix_out.ready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected beat", pix_out.out_x, pix_out.out_y, 0, 0);
      end else begin
        want = pending_pixels.pop_front();
        if (pix_out.out_x !== want.x)
          report_mismatch("out_x", want.x, want.y, pix_out.out_x, want.x);
        if (pix_out.out_y !== want.y)
          report_mismatch("out_y", want.x, want.y, pix_out.out_y, want.y);
        if (pix_out.pixel_colour !== want.colour)
          report_mismatch("pixel_colour", want.x, want.y, pix_out.pixel_colour, want.colour);
        if (pix_out.escaped !== want.escaped)
          report_mismatch("escaped", want.x, want.y, pix_out.escaped, want.escaped);
        if (pix_out.iterations_done !== want.iterations)
          report_mismatch("iterations_done", want.x, want.y, pix_out.iterations_done,
                          want.iterations);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_ITER_LIMIT;
    cfg_data = '0;
    pix_in.valid = 1'b0;
    pix_in.pixel_x = '0;
    pix_in.pixel_y = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_power_on_defaults();
    test_register_extremes();
    test_colour_wraparound();
    test_random_frames();
    settle_pipeline();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/bsp_pkg.sv
hdl/bsp_if.sv
hdl/bsp_front.sv
hdl/bsp_queue.sv
hdl/bsp_back.sv
hdl/burning_ship_pixel_iterator.sv
dv/testbench.sv
